FILE: hw/rtl/hwmm_pkg.sv
// ----------------------------------------------------------------------------
// hwmm_pkg
// Shared constants and types of the hue weighted mono mixer.
// ----------------------------------------------------------------------------
package hwmm_pkg;

  localparam int NBANDS  = 8;
  localparam int CH_W    = 17;   // input and output channel width
  localparam int WGT_W   = 8;    // band weight register width
  localparam int ADDR_W  = 5;    // byte address of eight 32-bit registers
  localparam int LUMA_W  = 35;   // exact luma accumulator
  localparam int SAT_W   = 33;   // saturation, Q.16, unbounded above
  localparam int HUE_W   = 16;   // hue, Q0.16 of a turn
  localparam int BW_W    = 17;   // band window weight, 0..65536
  localparam int ONE16   = 65536;
  localparam int W_FLOOR = 65;   // w * 1000 > 65536  <=>  w > 65

  localparam logic signed [LUMA_W-1:0] COEF_R = 35'sd17216;
  localparam logic signed [LUMA_W-1:0] COEF_G = 35'sd44434;
  localparam logic signed [LUMA_W-1:0] COEF_B = 35'sd3886;

  localparam logic [HUE_W-1:0] BAND_CENTRE [NBANDS] = '{
    16'd0, 16'd5439, 16'd10945, 16'd21823, 16'd32768, 16'd40042, 16'd50987, 16'd58262
  };

  typedef struct packed {
    logic signed [LUMA_W-1:0] luma;
    logic [SAT_W-1:0]         sat;
  } hwmm_ctx_t;

endpackage

FILE: hw/rtl/hwmm_div.sv
// ----------------------------------------------------------------------------
// hwmm_div
// Pipelined restoring divider, one quotient bit per register stage.
// The top DEN_W bits of the dividend must be below the divisor.
// ----------------------------------------------------------------------------
module hwmm_div #(
  parameter int DEN_W  = 20,
  parameter int Q_W    = 33,
  parameter int SIDE_W = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   vld_i,
  input  logic [DEN_W+Q_W-1:0]   num_i,
  input  logic [DEN_W-1:0]       den_i,
  input  logic [SIDE_W-1:0]      side_i,
  output logic                   vld_o,
  output logic [Q_W-1:0]         quot_o,
  output logic [SIDE_W-1:0]      side_o
);

  logic              vld_q  [Q_W];
  logic [DEN_W-1:0]  rem_q  [Q_W];
  logic [DEN_W-1:0]  den_q  [Q_W];
  logic [Q_W-1:0]    lq_q   [Q_W];   // low dividend bits shift out, quotient bits in
  logic [SIDE_W-1:0] side_q [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_step
    logic              vld_in;
    logic [DEN_W-1:0]  rem_in;
    logic [DEN_W-1:0]  den_in;
    logic [Q_W-1:0]    lq_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    rem2;
    logic [DEN_W:0]    diff;
    logic              ge;

    if (i == 0) begin : g_first
      assign vld_in  = vld_i;
      assign rem_in  = num_i[DEN_W+Q_W-1:Q_W];
      assign den_in  = den_i;
      assign lq_in   = num_i[Q_W-1:0];
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign den_in  = den_q[i-1];
      assign lq_in   = lq_q[i-1];
      assign side_in = side_q[i-1];
    end

    assign rem2 = {rem_in, lq_in[Q_W-1]};
    assign diff = rem2 - {1'b0, den_in};
    assign ge   = rem2 >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i]  <= ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
      den_q[i]  <= den_in;
      lq_q[i]   <= {lq_in[Q_W-2:0], ge};
      side_q[i] <= side_in;
    end
  end

  assign vld_o  = vld_q[Q_W-1];
  assign quot_o = lq_q[Q_W-1];
  assign side_o = side_q[Q_W-1];

endmodule

FILE: hw/rtl/hwmm_window.sv
// ----------------------------------------------------------------------------
// hwmm_window
// Smoothstep window weight of the hue for each of the eight bands,
// three register stages: distance, square, cubic term.
// ----------------------------------------------------------------------------
module hwmm_window import hwmm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vld_i,
  input  logic [HUE_W-1:0] hue_i,
  input  hwmm_ctx_t        ctx_i,
  output logic             vld_o,
  output logic [BW_W-1:0]  wgt_o [NBANDS],
  output hwmm_ctx_t        ctx_o
);

  logic            vld1_q, vld2_q, vld3_q;
  hwmm_ctx_t       ctx1_q, ctx2_q, ctx3_q;
  logic [16:0]     t1_q  [NBANDS];
  logic [16:0]     t2_q  [NBANDS];
  logic [17:0]     k2_q  [NBANDS];
  logic [BW_W-1:0] w3_q  [NBANDS];

  for (genvar i = 0; i < NBANDS; i++) begin : g_band
    logic [HUE_W-1:0] hue_dist;
    logic [16:0]      fold;
    logic [17:0]      six_d;
    logic [16:0]      t_d;
    logic [33:0]      tt;
    logic [34:0]      tk;

    // circular distance to the band centre, then t = max(0, 1 - 6d)
    always_comb begin
      hue_dist = (hue_i >= BAND_CENTRE[i]) ? hue_i - BAND_CENTRE[i]
                                           : BAND_CENTRE[i] - hue_i;
      fold  = ({1'b0, hue_dist} > 17'd32768) ? 17'(ONE16) - {1'b0, hue_dist}
                                             : {1'b0, hue_dist};
      six_d = {fold, 1'b0} + {1'b0, fold} + {1'b0, fold} + {1'b0, fold}
            + {1'b0, fold} + {1'b0, fold} - {1'b0, fold};
      t_d   = (six_d < 18'(ONE16)) ? 17'(18'(ONE16) - six_d) : 17'd0;
    end

    assign tt = 34'(t1_q[i]) * 34'(t1_q[i]);
    assign tk = 35'(t2_q[i]) * 35'(k2_q[i]);

    always_ff @(posedge clk_i) begin
      t1_q[i] <= t_d;
      t2_q[i] <= tt[32:16];
      k2_q[i] <= 18'd196608 - {t1_q[i], 1'b0};
      w3_q[i] <= tk[32:16];
    end

    assign wgt_o[i] = w3_q[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ctx1_q <= ctx_i;
    ctx2_q <= ctx1_q;
    ctx3_q <= ctx2_q;
  end

  assign vld_o = vld3_q;
  assign ctx_o = ctx3_q;

endmodule

FILE: hw/rtl/hue_weighted_mono_mix.sv
// ----------------------------------------------------------------------------
// hue_weighted_mono_mix
// Black-and-white conversion of one linear RGB pixel with a hue dependent
// gain taken from eight configurable band weights.
// ----------------------------------------------------------------------------
// One pixel is taken on every clock in which start_i is high; busy_o stays
// low, so the block never refuses a word. Each grey word appears on grey_o
// for one cycle with done_o high, in order. The receiver cannot stall the
// output: it must take each word in the cycle in which done_o is high. The
// pipeline holds two bit-per-stage dividers in series: 33 stages for hue
// and saturation (run side by side) and 34 stages for the weighted gain.
// Band weights are written through the APB port at byte address 4*i and
// must only change while no pixel is in flight.
module hue_weighted_mono_mix import hwmm_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic signed [CH_W-1:0] red_i,
  input  logic signed [CH_W-1:0] green_i,
  input  logic signed [CH_W-1:0] blue_i,
  output logic                   done_o,
  output logic [CH_W-1:0]        grey_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int EPS_THR  = (1 << FRAC_BITS) / 100000;
  localparam int LATENCY  = 82;
  localparam logic [16:0]        EPS_U = 17'(EPS_THR);
  localparam logic signed [16:0] EPS_S = 17'(EPS_THR);

  // --------------------------------------------------------------------------
  // configuration registers
  logic [WGT_W-1:0] wreg_q [NBANDS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NBANDS; i++) wreg_q[i] <= '0;
    end else if (psel && penable && pwrite) begin
      wreg_q[paddr[ADDR_W-1:2]] <= pwdata[WGT_W-1:0];
    end
  end

  assign prdata = {24'd0, wreg_q[paddr[ADDR_W-1:2]]};
  assign pready = 1'b1;
  assign busy_o = 1'b0;

  // --------------------------------------------------------------------------
  // front end: max/min, luma products, hue numerator
  logic                   v1_q, v2_q, v3_q;
  logic signed [CH_W-1:0] r1_q, g1_q, b1_q, r2_q, g2_q, b2_q;
  logic signed [CH_W-1:0] mx_d, mn_d, mx2_q, mn2_q;
  logic signed [LUMA_W-1:0] pr2_q, pg2_q, pb2_q;

  always_comb begin
    mx_d = r1_q;
    if (g1_q > mx_d) mx_d = g1_q;
    if (b1_q > mx_d) mx_d = b1_q;
    mn_d = r1_q;
    if (g1_q < mn_d) mn_d = g1_q;
    if (b1_q < mn_d) mn_d = b1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    r1_q  <= red_i;
    g1_q  <= green_i;
    b1_q  <= blue_i;
    r2_q  <= r1_q;
    g2_q  <= g1_q;
    b2_q  <= b1_q;
    mx2_q <= mx_d;
    mn2_q <= mn_d;
    pr2_q <= LUMA_W'(r1_q) * COEF_R;
    pg2_q <= LUMA_W'(g1_q) * COEF_G;
    pb2_q <= LUMA_W'(b1_q) * COEF_B;
  end

  logic signed [17:0]       dlt_s;
  logic [16:0]              delta;
  logic [19:0]              d6;
  logic signed [20:0]       num_s;
  logic [19:0]              num3_q, d63_q;
  logic [16:0]              delta3_q;
  logic signed [CH_W-1:0]   mx3_q;
  logic signed [LUMA_W-1:0] luma3_q;
  logic                     hok3_q, sok3_q;

  always_comb begin
    dlt_s = 18'(mx2_q) - 18'(mn2_q);
    delta = dlt_s[16:0];
    d6    = {1'b0, delta, 2'b00} + {2'b00, delta, 1'b0};
    // red wins ties over green, green over blue
    if (mx2_q == r2_q) begin
      num_s = 21'(g2_q) - 21'(b2_q) + ((g2_q < b2_q) ? $signed({1'b0, d6}) : 21'sd0);
    end else if (mx2_q == g2_q) begin
      num_s = 21'(b2_q) - 21'(r2_q) + $signed({3'b000, delta, 1'b0});
    end else begin
      num_s = 21'(r2_q) - 21'(g2_q) + $signed({2'b00, delta, 2'b00});
    end
  end

  always_ff @(posedge clk_i) begin
    num3_q   <= num_s[19:0];
    d63_q    <= d6;
    delta3_q <= delta;
    mx3_q    <= mx2_q;
    luma3_q  <= pr2_q + pg2_q + pb2_q;
    hok3_q   <= delta > EPS_U;
    sok3_q   <= mx2_q > EPS_S;
  end

  // --------------------------------------------------------------------------
  // hue and saturation dividers, same depth
  logic             hvld, svld, hok, sok;
  logic [SAT_W-1:0] hq, sq;
  logic signed [LUMA_W-1:0] luma_s;
  logic [HUE_W-1:0] hue_w;
  hwmm_ctx_t        ctx_w;

  hwmm_div #(.DEN_W(20), .Q_W(SAT_W), .SIDE_W(1)) u_div_hue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (v3_q),
    .num_i  ({num3_q, {SAT_W{1'b0}}}),
    .den_i  (d63_q),
    .side_i (hok3_q),
    .vld_o  (hvld),
    .quot_o (hq),
    .side_o (hok)
  );

  hwmm_div #(.DEN_W(16), .Q_W(SAT_W), .SIDE_W(LUMA_W+1)) u_div_sat (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (v3_q),
    .num_i  ({16'd0, delta3_q, 16'd0}),
    .den_i  (mx3_q[15:0]),
    .side_i ({luma3_q, sok3_q}),
    .vld_o  (svld),
    .quot_o (sq),
    .side_o ({luma_s, sok})
  );

  // hue carries 17 extra fraction bits, dropped here
  assign hue_w     = hok ? hq[SAT_W-1 -: HUE_W] : '0;
  assign ctx_w.luma = luma_s;
  assign ctx_w.sat  = sok ? sq : '0;

  logic            wvld;
  logic [BW_W-1:0] wgt [NBANDS];
  hwmm_ctx_t       wctx;

  hwmm_window u_win (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (svld),
    .hue_i  (hue_w),
    .ctx_i  (ctx_w),
    .vld_o  (wvld),
    .wgt_o  (wgt),
    .ctx_o  (wctx)
  );

  // --------------------------------------------------------------------------
  // weighted sum of band weights, then weighted * saturation
  logic              g1_v_q, g2_v_q, g3_v_q, g4_v_q, g5_v_q;
  logic signed [25:0] prod1_q [NBANDS];
  logic [BW_W-1:0]   wm1_q [NBANDS];
  hwmm_ctx_t         ctx1_q, ctx2_q, ctx3_q, ctx4_q, ctx5_q;
  logic signed [26:0] wsum_d, wsum2_q;
  logic [19:0]       tsum_d, tsum2_q;
  logic [26:0]       aw3_q;
  logic              sgn3_q, sgn4_q, sgn5_q, gon3_q, gon4_q, gon5_q;
  logic [25:0]       den3_q, den4_q, den5_q;
  logic [43:0]       pl4_q;
  logic [42:0]       ph4_q;
  logic [59:0]       prod5_q;

  always_comb begin
    wsum_d = '0;
    tsum_d = '0;
    for (int i = 0; i < NBANDS; i++) begin
      wsum_d = wsum_d + 27'(prod1_q[i]);
      tsum_d = tsum_d + 20'(wm1_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g1_v_q <= 1'b0;
      g2_v_q <= 1'b0;
      g3_v_q <= 1'b0;
      g4_v_q <= 1'b0;
      g5_v_q <= 1'b0;
    end else begin
      g1_v_q <= wvld;
      g2_v_q <= g1_v_q;
      g3_v_q <= g2_v_q;
      g4_v_q <= g3_v_q;
      g5_v_q <= g4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NBANDS; i++) begin
      // bands at or below the floor do not count
      wm1_q[i]   <= (wgt[i] > BW_W'(W_FLOOR)) ? wgt[i] : '0;
      prod1_q[i] <= 26'($signed(wreg_q[i]))
                  * $signed({9'd0, (wgt[i] > BW_W'(W_FLOOR)) ? wgt[i] : 17'd0});
    end
    ctx1_q  <= wctx;
    wsum2_q <= wsum_d;
    tsum2_q <= tsum_d;
    ctx2_q  <= ctx1_q;
    sgn3_q  <= wsum2_q[26];
    aw3_q   <= wsum2_q[26] ? 27'(-wsum2_q) : 27'(wsum2_q);
    den3_q  <= 26'(tsum2_q) * 26'd100;
    gon3_q  <= tsum2_q > 20'(W_FLOOR);
    ctx3_q  <= ctx2_q;
    pl4_q   <= 44'(aw3_q) * 44'(ctx3_q.sat[16:0]);
    ph4_q   <= 43'(aw3_q) * 43'(ctx3_q.sat[SAT_W-1:17]);
    sgn4_q  <= sgn3_q;
    gon4_q  <= gon3_q;
    den4_q  <= den3_q;
    ctx4_q  <= ctx3_q;
    prod5_q <= 60'(pl4_q) + {ph4_q, 17'd0};
    sgn5_q  <= sgn4_q;
    gon5_q  <= gon4_q;
    den5_q  <= den4_q;
    ctx5_q  <= ctx4_q;
  end

  // --------------------------------------------------------------------------
  // gain divider: |weighted * sat| / (100 * total)
  logic                     gvld, gsgn, ggon;
  logic [33:0]              gq;
  logic signed [LUMA_W-1:0] gluma;

  hwmm_div #(.DEN_W(26), .Q_W(34), .SIDE_W(LUMA_W+2)) u_div_gain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (g5_v_q),
    .num_i  (prod5_q),
    .den_i  (den5_q),
    .side_i ({ctx5_q.luma, sgn5_q, gon5_q}),
    .vld_o  (gvld),
    .quot_o (gq),
    .side_o ({gluma, gsgn, ggon})
  );

  // --------------------------------------------------------------------------
  // gain, magnitudes, split product, clamp
  logic                     v6_q, v7_q, v8_q, done_q;
  logic signed [35:0]       gain6_q;
  logic signed [LUMA_W-1:0] luma6_q;
  logic                     pos7_q, pos8_q;
  logic [32:0]              ml7_q;
  logic [34:0]              mg7_q;
  logic [50:0]              plo8_q;
  logic [49:0]              phi8_q;
  logic [67:0]              full;
  logic [CH_W-1:0]          grey_d, grey_q;

  assign full   = 68'(plo8_q) + {phi8_q, 18'd0};
  assign grey_d = !pos8_q ? '0 : ((|full[67:49]) ? '1 : full[48:32]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q   <= 1'b0;
      v7_q   <= 1'b0;
      v8_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v6_q   <= gvld;
      v7_q   <= v6_q;
      v8_q   <= v7_q;
      done_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ggon) begin
      gain6_q <= 36'(ONE16);
    end else if (gsgn) begin
      gain6_q <= 36'(ONE16) - $signed({2'b00, gq});
    end else begin
      gain6_q <= 36'(ONE16) + $signed({2'b00, gq});
    end
    luma6_q <= gluma;
    pos7_q  <= (luma6_q > 0 && gain6_q > 0) || (luma6_q < 0 && gain6_q < 0);
    ml7_q   <= luma6_q[LUMA_W-1] ? 33'(-luma6_q) : 33'(luma6_q);
    mg7_q   <= gain6_q[35] ? 35'(-gain6_q) : 35'(gain6_q);
    pos8_q  <= pos7_q;
    plo8_q  <= 51'(ml7_q) * 51'(mg7_q[17:0]);
    phi8_q  <= 50'(ml7_q) * 50'(mg7_q[34:18]);
    grey_q  <= grey_d;
  end

  assign done_o = done_q;
  assign grey_o = grey_q;

  // --------------------------------------------------------------------------
  a_div_align: assert property (@(posedge clk_i) disable iff (!rst_ni) hvld == svld)
    else $error("hue and saturation dividers out of step");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##LATENCY done_o)
    else $error("accepted word did not come out on time");

  a_no_sign_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !$past(pos8_q) |-> grey_o == '0)
    else $error("non-positive product gave nonzero grey");

endmodule

FILE: test/tb_hue_weighted_mono_mix.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hue_weighted_mono_mix
// Self-checking bench for the hue weighted mono mixer. Pixels are sent from a
// queue with random gaps. Each accepted pixel gets its grey value predicted
// from the current band weights, and the prediction is compared with the
// done_o words in order. Band weights are rewritten over APB between phases,
// while no pixel is in flight.
// ----------------------------------------------------------------------------
module tb_hue_weighted_mono_mix import hwmm_pkg::*;;

  localparam int LATENCY   = 82;
  localparam int STALL_MAX = 5000;

  typedef struct {
    logic signed [CH_W-1:0] red;
    logic signed [CH_W-1:0] green;
    logic signed [CH_W-1:0] blue;
  } pixel_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start_i = 1'b0;
  logic                   busy_o;
  logic signed [CH_W-1:0] red_i = '0;
  logic signed [CH_W-1:0] green_i = '0;
  logic signed [CH_W-1:0] blue_i = '0;
  logic                   done_o;
  logic [CH_W-1:0]        grey_o;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [ADDR_W-1:0]      paddr = '0;
  logic [31:0]            pwdata = '0;
  logic [31:0]            prdata;
  logic                   pready;

  pixel_t              pixel_q[$];
  logic [CH_W-1:0]     grey_q[$];
  logic signed [7:0]   band_wgt[NBANDS];
  int                  errors = 0;
  int                  stall_cnt = 0;
  int                  gap = 0;
  bit                  took_word = 1'b0;

  hue_weighted_mono_mix #(.FRAC_BITS(14)) u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // smoothstep window of one sixth of a turn around a band centre
  function automatic longint band_window(longint hue, longint centre);
    longint d, t, t2;
    d = hue - centre;
    if (d < 0) d = -d;
    if (d > ONE16 / 2) d = ONE16 - d;
    t = ONE16 - 6 * d;
    if (t < 0) t = 0;
    t2 = (t * t) >>> 16;
    return (t2 * (3 * ONE16 - 2 * t)) >>> 16;
  endfunction

  function automatic logic [CH_W-1:0] mono_grey(pixel_t px);
    longint r, g, b, luma, mx, mn, delta, num, hue, sat, w, wsum, tot, gain;
    longint unsigned ml, mg, prod;
    r = longint'(px.red); g = longint'(px.green); b = longint'(px.blue);
    hue = 0; sat = 0; wsum = 0; tot = 0; gain = ONE16;
    luma = 17216 * r + 44434 * g + 3886 * b;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
    if (delta * 100000 > (64'sd1 << 14)) begin
      if (mx == r) num = (g - b) + (g < b ? 6 * delta : 0);
      else if (mx == g) num = (b - r) + 2 * delta;
      else num = (r - g) + 4 * delta;
      hue = (num * ONE16) / (6 * delta);
      if (hue < 0) hue = 0;
      if (hue > ONE16 - 1) hue = ONE16 - 1;
    end
    if (mx * 100000 > (64'sd1 << 14)) sat = (delta * ONE16) / mx;
    for (int i = 0; i < NBANDS; i++) begin
      w = band_window(hue, longint'(BAND_CENTRE[i]));
      if (w * 1000 > ONE16) begin
        wsum += longint'(band_wgt[i]) * w;
        tot += w;
      end
    end
    if (tot * 1000 > ONE16) gain = ONE16 + (wsum * sat) / (100 * tot);
    ml = luma < 0 ? -luma : luma;
    mg = gain < 0 ? -gain : gain;
    if (ml == 0 || mg == 0 || ((luma < 0) != (gain < 0))) return '0;
    if (mg > 64'h4000_0000_0000_0000 / ml) return 17'h1FFFF;
    prod = (ml * mg) >> 32;
    if (prod > 131071) prod = 131071;
    return prod[CH_W-1:0];
  endfunction

  // driver: holds a word until accepted, then waits a random gap
  always @(negedge clk_i) begin
    pixel_t px;
    if (rst_ni && !(start_i && !took_word)) begin
      if (gap > 0) begin
        gap <= gap - 1;
        start_i <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        px = pixel_q.pop_front();
        red_i <= px.red;
        green_i <= px.green;
        blue_i <= px.blue;
        start_i <= 1'b1;
        gap <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 6));
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor: predict on accept, check on done
  always @(posedge clk_i) begin
    pixel_t px;
    logic [CH_W-1:0] exp_grey;
    took_word = start_i && !busy_o && rst_ni;
    if (took_word) begin
      px.red = red_i; px.green = green_i; px.blue = blue_i;
      grey_q.push_back(mono_grey(px));
    end
    if (rst_ni && done_o) begin
      if (grey_q.size() == 0) begin
        $error("grey word with no pixel pending: actual %0d", grey_o);
        errors++;
      end else begin
        exp_grey = grey_q.pop_front();
        if (grey_o !== exp_grey) begin
          $error("grey mismatch: expected %0d actual %0d", exp_grey, grey_o);
          errors++;
        end
      end
    end
    if (took_word || done_o || psel) stall_cnt = 0;
    else stall_cnt++;
    if (stall_cnt >= STALL_MAX) begin
      $display("hue_weighted_mono_mix regression: fail");
      $finish;
    end
  end

  task automatic add_pixel(int r, int g, int b);
    pixel_t px;
    px.red = CH_W'(r); px.green = CH_W'(g); px.blue = CH_W'(b);
    pixel_q.push_back(px);
  endtask

  task automatic drain();
    while (pixel_q.size() != 0 || start_i || grey_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_band(int idx, logic signed [7:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_W'(4 * idx); pwdata <= {{24{val[7]}}, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    band_wgt[idx] = val;
  endtask

  task automatic directed_pixels();
    add_pixel(0, 0, 0);
    add_pixel(16384, 16384, 16384);          // grey, flat
    add_pixel(16384, 16385, 16384);          // smallest delta
    add_pixel(65535, 65535, 65535);
    add_pixel(-65536, -65536, -65536);
    add_pixel(16384, 0, 0);                  // red
    add_pixel(16384, 8000, 0);               // orange
    add_pixel(16384, 16384, 0);              // yellow tie, red wins
    add_pixel(0, 16384, 0);                  // green
    add_pixel(0, 16384, 16384);              // aqua tie, green wins
    add_pixel(0, 0, 16384);                  // blue
    add_pixel(9000, 0, 16384);               // purple
    add_pixel(16384, 0, 12000);              // magenta
    add_pixel(0, 0, 0);
    add_pixel(0, 1, 0);                      // smallest positive max
    add_pixel(-100, -50, -200);              // negative max
    add_pixel(16384, -16384, 0);             // saturation above one
    add_pixel(1, -65536, -65536);            // huge saturation
    add_pixel(65535, -65536, -65536);
    add_pixel(-65536, 65535, -65536);
    add_pixel(-65536, -65536, 65535);
    add_pixel(65535, 65535, -65536);
  endtask

  task automatic random_pixels(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 7)
        add_pixel($urandom_range(0, 24000), $urandom_range(0, 24000),
                  $urandom_range(0, 24000));
      else
        add_pixel($urandom_range(0, 131071) - 65536, $urandom_range(0, 131071) - 65536,
                  $urandom_range(0, 131071) - 65536);
    end
  endtask

  initial begin
    for (int i = 0; i < NBANDS; i++) band_wgt[i] = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        drain();
        for (int i = 0; i < NBANDS; i++) begin
          case (ph)
            1: write_band(i, 8'sd100);
            2: write_band(i, -8'sd100);
            3: write_band(i, (i % 2) ? 8'sd127 : -8'sd128);
            default: write_band(i, 8'($urandom_range(0, 255)));
          endcase
        end
      end
      directed_pixels();
      random_pixels(150);
      if (ph == 2) drain();  // let the pipe run dry once
      random_pixels(150);
    end
    drain();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (errors == 0) $display("hue_weighted_mono_mix regression: pass");
    else $display("hue_weighted_mono_mix regression: fail");
    $finish;
  end

endmodule
